// File: rtl/fcgi_pkg.sv
// Shared types and constants for the FastCGI record deframer.
// No dependencies; imported by every module of the block.
package fcgi_pkg;

    localparam logic [7:0]  TYPE_END_REQ     = 8'd3;
    localparam logic [7:0]  TYPE_STDOUT      = 8'd6;
    localparam logic [7:0]  TYPE_STDERR      = 8'd7;
    localparam logic [15:0] DEFAULT_REQ_ID   = 16'd1;

    localparam logic [2:0]  HDR_LAST_IDX     = 3'd7;

    // Event codes on the result channel
    localparam logic [1:0]  EV_DATA     = 2'd0;
    localparam logic [1:0]  EV_END      = 2'd1;
    localparam logic [1:0]  EV_MISMATCH = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_CONTENT = 2'd1,
        PH_PADDING = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic [7:0] data_byte;
        logic       from_stderr;
        logic       stderr_only;
    } result_t;

endpackage

// File: rtl/fcgi_parse.sv
// Record parser: header gathering, content/padding counting, event decode.
// Depends on fcgi_pkg.
module fcgi_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    input  logic [15:0]       exp_req_id,
    output logic              res_valid,
    output fcgi_pkg::result_t res
);
    import fcgi_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [2:0]  hdr_idx_reg, hdr_idx_next;
    logic [7:0]  rec_type_reg, rec_type_next;
    logic [15:0] rec_id_reg, rec_id_next;
    logic [15:0] content_left_reg, content_left_next;
    logic [7:0]  padding_left_reg, padding_left_next;
    logic        saw_stdout_reg, saw_stdout_next;
    logic        saw_stderr_reg, saw_stderr_next;

    logic is_end, is_stdout, is_stderr;
    logic content_last, pad_last, hdr_last, id_bad;
    logic in_content, in_padding, in_header;
    logic data_hit, end_hit, mismatch_hit;

    assign is_end       = (rec_type_reg == TYPE_END_REQ);
    assign is_stdout    = (rec_type_reg == TYPE_STDOUT);
    assign is_stderr    = (rec_type_reg == TYPE_STDERR);
    assign content_last = (content_left_reg == 16'd1);
    assign pad_last     = (padding_left_reg == 8'd1);
    assign hdr_last     = (hdr_idx_reg == HDR_LAST_IDX);
    assign id_bad       = (rec_id_reg != exp_req_id);

    assign in_content = (phase_reg == PH_CONTENT);
    assign in_padding = (phase_reg == PH_PADDING);
    assign in_header  = !in_content && !in_padding;

    assign data_hit     = in_content && (is_stdout || is_stderr);
    assign mismatch_hit = in_header && hdr_last && id_bad && !is_end;
    assign end_hit      = is_end && (
                              (in_content && content_last && (padding_left_reg == 8'd0))
                           || (in_padding && pad_last)
                           || (in_header && hdr_last && (content_left_reg == 16'd0)
                               && (padding_left_reg == 8'd0)));

    // Next state
    always_comb
    begin
        phase_next        = phase_reg;
        hdr_idx_next      = hdr_idx_reg;
        rec_type_next     = rec_type_reg;
        rec_id_next       = rec_id_reg;
        content_left_next = content_left_reg;
        padding_left_next = padding_left_reg;
        saw_stdout_next   = saw_stdout_reg;
        saw_stderr_next   = saw_stderr_reg;

        unique case (phase_reg)
            PH_CONTENT:
            begin
                content_left_next = content_left_reg - 16'd1;
                if (is_stdout)
                    saw_stdout_next = 1'b1;
                if (is_stderr)
                    saw_stderr_next = 1'b1;
                if (content_last)
                begin
                    if (padding_left_reg != 8'd0)
                        phase_next = PH_PADDING;
                    else
                    begin
                        phase_next   = PH_HEADER;
                        hdr_idx_next = 3'd0;
                    end
                end
            end
            PH_PADDING:
            begin
                padding_left_next = padding_left_reg - 8'd1;
                if (pad_last)
                begin
                    phase_next   = PH_HEADER;
                    hdr_idx_next = 3'd0;
                end
            end
            default:
            begin
                // Unused phase code behaves as header phase
                phase_next   = PH_HEADER;
                hdr_idx_next = hdr_idx_reg + 3'd1;
                case (hdr_idx_reg)
                    3'd1: rec_type_next = rx_byte;
                    3'd2: rec_id_next = {rx_byte, rec_id_reg[7:0]};
                    3'd3: rec_id_next = {rec_id_reg[15:8], rx_byte};
                    3'd4: content_left_next = {rx_byte, content_left_reg[7:0]};
                    3'd5: content_left_next = {content_left_reg[15:8], rx_byte};
                    3'd6: padding_left_next = rx_byte;
                    default: ;
                endcase
                if (hdr_last && !mismatch_hit)
                begin
                    if (content_left_reg != 16'd0)
                        phase_next = PH_CONTENT;
                    else if (padding_left_reg != 8'd0)
                        phase_next = PH_PADDING;
                end
            end
        endcase

        if (end_hit || mismatch_hit)
        begin
            saw_stdout_next = 1'b0;
            saw_stderr_next = 1'b0;
        end
    end

    // Result decode
    always_comb
    begin
        res           = '0;
        res_valid     = accept && (data_hit || end_hit || mismatch_hit);
        if (data_hit)
        begin
            res.event_res   = EV_DATA;
            res.data_byte   = rx_byte;
            res.from_stderr = is_stderr;
        end
        else if (end_hit)
        begin
            res.event_res   = EV_END;
            res.stderr_only = saw_stderr_reg && !saw_stdout_reg;
        end
        else if (mismatch_hit)
            res.event_res = EV_MISMATCH;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            hdr_idx_reg      <= 3'd0;
            rec_type_reg     <= 8'd0;
            rec_id_reg       <= 16'd0;
            content_left_reg <= 16'd0;
            padding_left_reg <= 8'd0;
            saw_stdout_reg   <= 1'b0;
            saw_stderr_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            hdr_idx_reg      <= hdr_idx_next;
            rec_type_reg     <= rec_type_next;
            rec_id_reg       <= rec_id_next;
            content_left_reg <= content_left_next;
            padding_left_reg <= padding_left_next;
            saw_stdout_reg   <= saw_stdout_next;
            saw_stderr_reg   <= saw_stderr_next;
        end
    end

`ifndef ASSERT_OFF
    a_mismatch_on_last_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.event_res == EV_MISMATCH) |-> (in_header && hdr_last))
        else $error("id mismatch reported outside last header byte");

    a_flags_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.event_res == EV_END) |=> (!saw_stdout_reg && !saw_stderr_reg))
        else $error("seen flags not cleared after end of request");

    a_content_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CONTENT) |-> (content_left_reg != 16'd0))
        else $error("content phase with no content left");
`endif

endmodule

// File: rtl/fcgi_skid.sv
// Result register with one skid entry, decoupling the parser from output stall.
// Depends on fcgi_pkg.
module fcgi_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fcgi_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output fcgi_pkg::result_t out_data
);
    import fcgi_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    pop;

    assign pop = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                // advance the held result
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            // output stalled: park the new result
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("result pushed while skid entry occupied");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry not moved to output after transfer");
`endif

endmodule

// File: rtl/fastcgi_record_deframer_unit.sv
// Top level of the FastCGI response record deframer.
// Depends on fcgi_pkg, fcgi_parse and fcgi_skid.
//
// Takes a FastCGI response stream one byte per transfer and takes one byte
// every clock while in_stall is low: each byte is decoded combinationally by
// the record parser (header byte counter, content and padding down-counters)
// and at most one result per byte is registered, in the output register or,
// while the output is stalled, in the one-entry skid stage behind it, which
// lets the input keep flowing until it is occupied; in_stall rises only then.
// Results: event_res 0 carries a stdout or stderr content byte (from_stderr
// tags the stream), 1 marks the end of a request once the end-request
// record's content and padding are consumed (stderr_only set if stderr bytes
// came and stdout bytes did not), 2 reports a header, not an end-request
// one, whose request id differs from the expected request id. Other record
// content, all padding and the version and reserved header bytes are dropped.
// After an end or a mismatch the parser waits for a fresh header. The expected
// request id resets to 1 and is written through cfg_we/cfg_wdata; the user
// must do so only while the block is idle; the block does not enforce this.
module fastcgi_record_deframer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_res,
    output logic [7:0]  data_byte,
    output logic        from_stderr,
    output logic        stderr_only
);
    import fcgi_pkg::*;

    logic [15:0] exp_id_reg;
    logic        accept;
    logic        res_valid;
    logic        skid_full;
    result_t     res;
    result_t     out_data;

    // Hold the expected request id until software writes a new one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            exp_id_reg <= DEFAULT_REQ_ID;
        else if (cfg_we)
            exp_id_reg <= cfg_wdata;
    end

    assign in_stall = skid_full;
    assign accept   = in_valid && !skid_full;

    fcgi_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (rx_byte),
        .exp_req_id (exp_id_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    fcgi_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (skid_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign event_res   = out_data.event_res;
    assign data_byte   = out_data.data_byte;
    assign from_stderr = out_data.from_stderr;
    assign stderr_only = out_data.stderr_only;

`ifndef ASSERT_OFF
    a_event_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_res == EV_DATA || event_res == EV_END
                       || event_res == EV_MISMATCH))
        else $error("undefined event code on output");

    a_data_zero_on_events: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res != EV_DATA) |-> (data_byte == 8'd0 && !from_stderr))
        else $error("payload not cleared on end or mismatch event");

    a_stall_only_when_backed_up: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with nothing waiting at the output");
`endif

endmodule

// File: test/fcgi_deframer_scoreboard_pkg.sv
// Scoreboard for the FastCGI record deframer testbench: tracks the record
// parser state, predicts each result and checks results in order.
// Depends on fcgi_pkg for the record types, event codes and result layout.
package fcgi_deframer_scoreboard_pkg;

    import fcgi_pkg::*;

    class fcgi_event_scoreboard;

        logic [15:0] req_id;
        phase_t      parse_phase;
        logic [2:0]  hdr_pos;
        logic [7:0]  rec_type;
        logic [15:0] rec_id;
        logic [15:0] content_left;
        logic [7:0]  pad_left;
        bit          seen_stdout;
        bit          seen_stderr;
        result_t     expected_events[$];
        int          failures;

        function new();
            req_id       = DEFAULT_REQ_ID;
            parse_phase  = PH_HEADER;
            hdr_pos      = '0;
            rec_type     = '0;
            rec_id       = '0;
            content_left = '0;
            pad_left     = '0;
            seen_stdout  = 1'b0;
            seen_stderr  = 1'b0;
            failures     = 0;
        endfunction

        function void set_req_id(logic [15:0] value);
            req_id = value;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function void push_event(logic [1:0] ev, logic [7:0] data, bit err, bit only);
            result_t r;
            r.event_res   = ev;
            r.data_byte   = data;
            r.from_stderr = err;
            r.stderr_only = only;
            expected_events.insert(expected_events.size(), r);
        endfunction

        // Record consumed: back to header wait; for an end-request record, report the end of a request.
        function void close_record();
            parse_phase = PH_HEADER;
            hdr_pos     = '0;
            if (rec_type == TYPE_END_REQ) begin
                push_event(EV_END, 8'h00, 1'b0, seen_stderr && !seen_stdout);
                seen_stdout = 1'b0;
                seen_stderr = 1'b0;
            end
        endfunction

        // Advance the parser by one accepted stream byte.
        function void note_rx_byte(logic [7:0] rx);
            case (parse_phase)
                PH_CONTENT:
                begin
                    if (rec_type == TYPE_STDOUT) begin
                        seen_stdout = 1'b1;
                        push_event(EV_DATA, rx, 1'b0, 1'b0);
                    end
                    else if (rec_type == TYPE_STDERR) begin
                        seen_stderr = 1'b1;
                        push_event(EV_DATA, rx, 1'b1, 1'b0);
                    end
                    content_left = content_left - 16'd1;
                    if (content_left == 16'd0) begin
                        if (pad_left != 8'd0)
                            parse_phase = PH_PADDING;
                        else
                            close_record();
                    end
                end
                PH_PADDING:
                begin
                    pad_left = pad_left - 8'd1;
                    if (pad_left == 8'd0)
                        close_record();
                end
                default:
                begin
                    parse_phase = PH_HEADER;
                    case (hdr_pos)
                        3'd1:    rec_type           = rx;
                        3'd2:    rec_id[15:8]       = rx;
                        3'd3:    rec_id[7:0]        = rx;
                        3'd4:    content_left[15:8] = rx;
                        3'd5:    content_left[7:0]  = rx;
                        3'd6:    pad_left           = rx;
                        default: ;
                    endcase
                    if (hdr_pos != HDR_LAST_IDX) begin
                        hdr_pos = hdr_pos + 3'd1;
                    end
                    else begin
                        hdr_pos = '0;
                        if (rec_id != req_id && rec_type != TYPE_END_REQ) begin
                            seen_stdout = 1'b0;
                            seen_stderr = 1'b0;
                            push_event(EV_MISMATCH, 8'h00, 1'b0, 1'b0);
                        end
                        else if (content_left != 16'd0)
                            parse_phase = PH_CONTENT;
                        else if (pad_left != 8'd0)
                            parse_phase = PH_PADDING;
                        else
                            close_record();
                    end
                end
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_events.size() == 0) begin
                $error("unexpected result: event_res %0d data_byte %0h", got.event_res,
                       got.data_byte);
                failures++;
                return;
            end
            want = expected_events.pop_front();
            if (got.event_res !== want.event_res) begin
                $error("event_res: expected %0d, got %0d", want.event_res, got.event_res);
                failures++;
            end
            if (got.data_byte !== want.data_byte) begin
                $error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
                failures++;
            end
            if (got.from_stderr !== want.from_stderr) begin
                $error("from_stderr: expected %0b, got %0b", want.from_stderr, got.from_stderr);
                failures++;
            end
            if (got.stderr_only !== want.stderr_only) begin
                $error("stderr_only: expected %0b, got %0b", want.stderr_only, got.stderr_only);
                failures++;
            end
        endfunction

    endclass

endpackage

// File: test/tb_fastcgi_record_deframer_unit.sv
// Top-level testbench for fastcgi_record_deframer_unit: drives FastCGI record
// streams, random stalls and request id settings, and checks every result.
// Depends on fcgi_pkg, fcgi_deframer_scoreboard_pkg and the deframer RTL.
module tb_fastcgi_record_deframer_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import fcgi_pkg::*;
    import fcgi_deframer_scoreboard_pkg::*;

    // Allows for the output register and the skid entry, with room to spare.
    localparam int DRAIN_CYCLES = 4;
    // Long enough to fill the output register and the skid entry many times over.
    localparam int HOLD_CYCLES  = 300;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  event_res;
    logic [7:0]  data_byte;
    logic        from_stderr;
    logic        stderr_only;

    fcgi_event_scoreboard sb;

    int          send_idle_pct;
    int          recv_stall_pct;
    int          bytes_sent;
    bit          hold_req;
    logic [15:0] cur_req_id;

    fastcgi_record_deframer_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_res   (event_res),
        .data_byte   (data_byte),
        .from_stderr (from_stderr),
        .stderr_only (stderr_only)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block locks up; far beyond the slowest correct run.
    initial
    begin
        #5ms;
        $display("fastcgi_record_deframer_unit: mismatch");
        $finish;
    end

    // Receiver: stall at the current rate, or hold off for a long stretch when
    // asked so that the skid entry fills and the input side stalls too.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Check every result transfer against the oldest prediction.
    always @(posedge clk)
    begin : result_monitor
        result_t seen;
        if (rst_n && out_valid && !out_stall) begin
            seen.event_res   = event_res;
            seen.data_byte   = data_byte;
            seen.from_stderr = from_stderr;
            seen.stderr_only = stderr_only;
            sb.check_result(seen);
        end
    end

    // Offer one stream byte and hold it until the transfer completes. Idle
    // cycles are decided before the byte is offered, never from in_stall.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_rx_byte(b);
        bytes_sent++;
    endtask

    // Eight header bytes in wire order: version, type, id, length, padding, reserved.
    task automatic send_header(input logic [7:0] ver, input logic [7:0] rtype,
                               input logic [15:0] id, input logic [15:0] clen,
                               input logic [7:0] plen, input logic [7:0] rsvd);
        send_byte(ver);
        send_byte(rtype);
        send_byte(id[15:8]);
        send_byte(id[7:0]);
        send_byte(clen[15:8]);
        send_byte(clen[7:0]);
        send_byte(plen);
        send_byte(rsvd);
    endtask

    // Drop valid and wait until every predicted result has been seen, then
    // allow for bytes still in flight that produce nothing.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_req_id(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        sb.set_req_id(value);
        cur_req_id = value;
        cfg_we    <= 1'b0;
    endtask

    // Mostly well-formed records with random content; the rest is stray bytes
    // and headers with a wrong id, which knock the parser out of step.
    task automatic send_random_record();
        int          pick;
        int          clen;
        int          plen;
        logic [7:0]  rtype;
        logic [15:0] rid;
        bit          wrong_id;
        pick = $urandom_range(99);
        if (pick < 5) begin
            repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(255)));
            return;
        end
        pick = $urandom_range(99);
        if (pick < 40)
            rtype = TYPE_STDOUT;
        else if (pick < 65)
            rtype = TYPE_STDERR;
        else if (pick < 82)
            rtype = TYPE_END_REQ;
        else
            rtype = 8'($urandom_range(255));
        rid = ($urandom_range(99) < 90) ? cur_req_id : 16'($urandom_range(65535));
        pick = $urandom_range(999);
        if (rtype == TYPE_END_REQ)
            clen = (pick < 700) ? 8 : $urandom_range(0, 3);
        else if (pick < 80)
            clen = 0;
        else if (pick < 980)
            clen = $urandom_range(1, 12);
        else if (pick < 992)
            clen = $urandom_range(13, 64);
        else
            clen = $urandom_range(256, 280);
        pick = $urandom_range(99);
        if (pick < 50)
            plen = 0;
        else if (pick < 95)
            plen = $urandom_range(1, 7);
        else if (pick < 99)
            plen = $urandom_range(8, 40);
        else
            plen = $urandom_range(200, 255);
        wrong_id = (rid != cur_req_id) && (rtype != TYPE_END_REQ);
        send_header(8'($urandom_range(255)), rtype, rid, 16'(clen), 8'(plen),
                    8'($urandom_range(255)));
        // A rejected header is usually followed by the next header at once.
        if (wrong_id && $urandom_range(99) < 80)
            return;
        repeat (clen) send_byte(8'($urandom_range(255)));
        repeat (plen) send_byte(8'($urandom_range(255)));
    endtask

    // Send records until the byte count is reached. At pause_at bytes, hold
    // the input until every result is out; at hold_at, ask the receiver to
    // hold off while the input keeps offering bytes.
    task automatic run_traffic(input int target, input int pause_at, input int hold_at);
        int  start;
        bit  paused;
        bit  held;
        start  = bytes_sent;
        paused = 1'b0;
        held   = 1'b0;
        while (bytes_sent - start < target) begin
            if (!paused && pause_at >= 0 && bytes_sent - start >= pause_at) begin
                paused = 1'b1;
                in_valid <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0) @(posedge clk);
            end
            if (!held && hold_at >= 0 && bytes_sent - start >= hold_at) begin
                held     = 1'b1;
                hold_req = 1'b1;
            end
            send_random_record();
        end
    endtask

    initial
    begin
        sb = new();
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        in_valid  <= 1'b0;
        rx_byte   <= '0;
        send_idle_pct  = 6;
        recv_stall_pct = 82;
        hold_req       = 1'b0;
        bytes_sent     = 0;
        cur_req_id     = DEFAULT_REQ_ID;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the request id at its reset value.
        // stderr byte, then an empty stdout record that must not count as
        // stdout data, then an end record whose id differs (end is exempt):
        // the end reports stderr only.
        send_header(8'h01, TYPE_STDERR, 16'h0001, 16'd1, 8'd0, 8'hFF);
        send_byte(8'hFF);
        send_header(8'h00, TYPE_STDOUT, 16'h0001, 16'd0, 8'd0, 8'h00);
        send_header(8'hFF, TYPE_END_REQ, 16'hFFFF, 16'd0, 8'd0, 8'h00);
        // stdout byte of zero with one padding byte to drop
        send_header(8'h01, TYPE_STDOUT, 16'h0001, 16'd1, 8'd1, 8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        // wrong request id on a stdout header
        send_header(8'h01, TYPE_STDOUT, 16'h0000, 16'd0, 8'd0, 8'h00);

        // Sender rarely idle, receiver mostly stalled; pause partway through.
        drain();
        write_req_id(16'hFFFF);
        run_traffic(550, 200, -1);

        // Sender mostly idle, receiver rarely stalled.
        drain();
        send_idle_pct  = 82;
        recv_stall_pct = 6;
        write_req_id(16'h0000);
        run_traffic(550, -1, -1);

        // Full rate on both sides, with one long receiver hold-off.
        drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_req_id(16'($urandom_range(65535)));
        run_traffic(550, -1, 250);

        drain();
        if (sb.failures == 0)
            $display("fastcgi_record_deframer_unit: match");
        else
            $display("fastcgi_record_deframer_unit: mismatch");
        $finish;
    end

endmodule
